// ===== rtl/afwd_pkg.sv =====
package afwd_pkg;

    // Sample store geometry
    localparam int STORE_DEPTH = 128;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W       = IDX_W + 9;

    // Field widths
    localparam int AXIS_W  = 13;
    localparam int MAG_W   = 14;
    localparam int WIN_W   = 8;
    localparam int THR_W   = 14;
    localparam int FILL_W  = 8;
    localparam int CFG_W   = 14;
    localparam int CFGI_W  = 2;

    // Queue depths between the parts
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    // Item modes / back-end operations
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_CHECK   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [CFGI_W-1:0] REG_LOW    = 2'd1;
    localparam logic [CFGI_W-1:0] REG_HIGH   = 2'd2;

    // Configuration reset values
    localparam logic [WIN_W-1:0] WINDOW_RST = 8'd25;
    localparam logic [THR_W-1:0] LOW_RST    = 14'd200;
    localparam logic [THR_W-1:0] HIGH_RST   = 14'd1300;

    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic [THR_W-1:0] low;
        logic [THR_W-1:0] high;
    } cfg_t;

    // Classified command handed from front to back
    typedef struct packed {
        logic [1:0]       op;
        logic [MAG_W-1:0] mag;
        logic             vib;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic              fall;
        logic              full;
        logic [FILL_W-1:0] pos;
    } res_t;

    // Absolute value of a two's complement axis reading
    function automatic logic [MAG_W-1:0] axis_mag(input logic [AXIS_W-1:0] v);
        logic [MAG_W-1:0] r;
        if (v[AXIS_W-1])
        begin
            r = MAG_W'(14'h2000) - MAG_W'(v);
        end
        else
        begin
            r = MAG_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== rtl/afwd_ram.sv =====
module afwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/afwd_front.sv =====
module afwd_front import afwd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        mode,
    input  logic [AXIS_W-1:0] accel_x,
    input  logic [AXIS_W-1:0] accel_y,
    input  logic [AXIS_W-1:0] accel_z,
    input  logic              vibrating,
    input  logic              batch_end,
    output logic              cmd_valid,
    output cmd_t              cmd,
    input  logic              cmd_take
);

    cmd_t                cmd_mem_reg [CMD_DEPTH];
    logic                cmd_wp_reg;
    logic                cmd_rp_reg;
    logic [1:0]          cmd_cnt_reg;
    logic [1:0]          cmd_cnt_next;
    logic                in_xfer;
    logic                out_xfer;
    cmd_t                cmd_new;
    logic [MAG_W:0]      mag_sum;

    assign full      = (cmd_cnt_reg == 2'(CMD_DEPTH));
    assign cmd_valid = (cmd_cnt_reg != 2'd0);
    assign cmd       = cmd_mem_reg[cmd_rp_reg];
    assign in_xfer   = push && !full;
    assign out_xfer  = cmd_take && cmd_valid;

    // Classify the incoming item and form the magnitude
    always_comb
    begin
        mag_sum = (MAG_W+1)'(axis_mag(accel_x)) + (MAG_W+1)'(axis_mag(accel_y))
                + (MAG_W+1)'(axis_mag(accel_z));
        cmd_new.mag  = mag_sum[MAG_W-1:0];
        cmd_new.vib  = vibrating;
        cmd_new.last = batch_end;
        case (mode)
            OP_SAMPLE:  cmd_new.op = OP_SAMPLE;
            OP_CHECK:   cmd_new.op = OP_CHECK;
            OP_RESTART: cmd_new.op = OP_RESTART;
            default:    cmd_new.op = OP_NONE;
        endcase
    end

    // Command queue occupancy
    always_comb
    begin
        cmd_cnt_next = cmd_cnt_reg;
        if (in_xfer && !out_xfer)
        begin
            cmd_cnt_next = cmd_cnt_reg + 2'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            cmd_cnt_next = cmd_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_wp_reg  <= 1'b0;
            cmd_rp_reg  <= 1'b0;
            cmd_cnt_reg <= 2'd0;
        end
        else
        begin
            cmd_cnt_reg <= cmd_cnt_next;
            if (in_xfer)
            begin
                cmd_wp_reg <= ~cmd_wp_reg;
            end
            if (out_xfer)
            begin
                cmd_rp_reg <= ~cmd_rp_reg;
            end
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_mem_reg[cmd_wp_reg] <= cmd_new;
        end
    end

    a_cmd_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_cnt_reg <= 2'(CMD_DEPTH))
        else $error("command queue over its depth");

    a_cmd_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_take) |=> cmd_valid)
        else $error("waiting command lost");

endmodule

// ===== rtl/afwd_back.sv =====
module afwd_back import afwd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              cmd_valid,
    input  cmd_t              cmd,
    output logic              cmd_take,
    output logic              empty,
    input  logic              pop,
    output logic              fall_detected,
    output logic              buffer_full,
    output logic [FILL_W-1:0] fill_position
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                   state_reg;
    logic                   state_next;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;
    logic                   full_reg;
    logic                   full_next;
    logic                   discard_reg;
    logic                   discard_next;
    logic [STORE_DEPTH-1:0] valid_reg;

    // Scan pipeline
    logic [IDX_W-1:0]       rd_idx_reg;
    logic                   rd_busy_reg;
    logic                   dat_v_reg;
    logic [IDX_W-1:0]       dat_idx_reg;
    logic                   dat_vb_reg;
    logic                   lastl_v_reg;
    logic [IDX_W-1:0]       lastl_reg;
    logic                   lasth_v_reg;
    logic [IDX_W-1:0]       lasth_reg;
    logic                   fall_acc_reg;

    logic [MAG_W-1:0]       ram_rdata;
    logic                   ram_we;
    logic                   scan_start;
    logic [MAG_W-1:0]       samp;
    logic                   cur_l;
    logic                   cur_h;
    logic                   nl_v;
    logic                   nh_v;
    logic [IDX_W-1:0]       nl;
    logic [IDX_W-1:0]       nh;
    logic [WIN_W-1:0]       win_m1;
    logic [CMP_W-1:0]       idx_c;
    logic [CMP_W-1:0]       wm1_c;
    logic                   win_any;
    logic                   end_ok;
    logic                   hit;
    logic                   fall_now;
    logic                   scan_last;

    // Result queue
    res_t                   res_mem_reg [RES_DEPTH];
    logic                   res_wp_reg;
    logic                   res_rp_reg;
    logic [1:0]             res_cnt_reg;
    logic [1:0]             res_cnt_next;
    logic                   res_push;
    logic                   res_pop;
    logic                   res_space;
    logic                   res_fall;
    res_t                   res_new;
    res_t                   res_head;

    afwd_ram #(
        .WIDTH (MAG_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg[IDX_W-1:0]),
        .wdata (cmd.mag),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign res_space = (res_cnt_reg != 2'(RES_DEPTH));
    assign cmd_take  = (state_reg == ST_IDLE) && cmd_valid && res_space;
    assign empty     = (res_cnt_reg == 2'd0);
    assign res_pop   = pop && !empty;
    assign res_head  = res_mem_reg[res_rp_reg];
    assign fall_detected = res_head.fall;
    assign buffer_full   = res_head.full;
    assign fill_position = res_head.pos;

    // Window test on the entry leaving the store: track the latest index
    // below the low threshold and above the high one, and see whether both
    // fall inside the window that ends here
    always_comb
    begin
        samp    = dat_vb_reg ? ram_rdata : '0;
        cur_l   = (samp < cfg.low);
        cur_h   = (samp > cfg.high);
        nl_v    = lastl_v_reg || cur_l;
        nh_v    = lasth_v_reg || cur_h;
        nl      = cur_l ? dat_idx_reg : lastl_reg;
        nh      = cur_h ? dat_idx_reg : lasth_reg;
        win_m1  = (cfg.window == '0) ? '0 : cfg.window - 1'b1;
        idx_c   = CMP_W'(dat_idx_reg);
        wm1_c   = CMP_W'(win_m1);
        win_any = (CMP_W'(cfg.window) < CMP_W'(STORE_DEPTH));
        scan_last = (dat_idx_reg == IDX_W'(STORE_DEPTH - 1));
        // last start position is one short of the end unless the window is empty
        end_ok  = (cfg.window == '0) || !scan_last;
        hit     = win_any && end_ok && (idx_c >= wm1_c) && nl_v && nh_v
                  && (CMP_W'(nl) + wm1_c >= idx_c) && (CMP_W'(nh) + wm1_c >= idx_c);
        fall_now = fall_acc_reg || hit;
    end

    // Command execution
    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        full_next    = full_reg;
        discard_next = discard_reg;
        ram_we       = 1'b0;
        res_push     = 1'b0;
        res_fall     = 1'b0;
        scan_start   = 1'b0;
        if (cmd_take)
        begin
            case (cmd.op)
                OP_SAMPLE:
                begin
                    res_push = 1'b1;
                    if (discard_reg)
                    begin
                        if (cmd.last)
                        begin
                            discard_next = 1'b0;
                        end
                    end
                    else if (pos_reg == POS_W'(STORE_DEPTH))
                    begin
                        pos_next     = '0;
                        full_next    = 1'b1;
                        discard_next = !cmd.last;
                    end
                    else if (!cmd.vib)
                    begin
                        ram_we   = 1'b1;
                        pos_next = pos_reg + 1'b1;
                    end
                end
                OP_CHECK:
                begin
                    state_next = ST_SCAN;
                    scan_start = 1'b1;
                end
                OP_RESTART:
                begin
                    res_push  = 1'b1;
                    pos_next  = '0;
                    full_next = 1'b0;
                end
                default:
                begin
                    res_push = 1'b1;
                end
            endcase
        end
        if ((state_reg == ST_SCAN) && dat_v_reg && scan_last)
        begin
            res_push   = 1'b1;
            res_fall   = fall_now;
            state_next = ST_IDLE;
        end
        res_new.fall = res_fall;
        res_new.full = full_next;
        res_new.pos  = FILL_W'(pos_next);
    end

    // Result queue occupancy
    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        if (res_push && !res_pop)
        begin
            res_cnt_next = res_cnt_reg + 2'd1;
        end
        else if (res_pop && !res_push)
        begin
            res_cnt_next = res_cnt_reg - 2'd1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            full_reg     <= 1'b0;
            discard_reg  <= 1'b0;
            valid_reg    <= '0;
            rd_idx_reg   <= '0;
            rd_busy_reg  <= 1'b0;
            dat_v_reg    <= 1'b0;
            dat_idx_reg  <= '0;
            dat_vb_reg   <= 1'b0;
            lastl_v_reg  <= 1'b0;
            lastl_reg    <= '0;
            lasth_v_reg  <= 1'b0;
            lasth_reg    <= '0;
            fall_acc_reg <= 1'b0;
            res_wp_reg   <= 1'b0;
            res_rp_reg   <= 1'b0;
            res_cnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            full_reg    <= full_next;
            discard_reg <= discard_next;
            if (ram_we)
            begin
                valid_reg[pos_reg[IDX_W-1:0]] <= 1'b1;
            end

            // read address sweep
            if (scan_start)
            begin
                rd_busy_reg  <= 1'b1;
                rd_idx_reg   <= '0;
                lastl_v_reg  <= 1'b0;
                lasth_v_reg  <= 1'b0;
                fall_acc_reg <= 1'b0;
            end
            else if (rd_busy_reg)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
                if (rd_idx_reg == IDX_W'(STORE_DEPTH - 1))
                begin
                    rd_busy_reg <= 1'b0;
                end
            end

            // data stage, aligned with the RAM read
            dat_v_reg   <= rd_busy_reg;
            dat_idx_reg <= rd_idx_reg;
            dat_vb_reg  <= valid_reg[rd_idx_reg];
            if (dat_v_reg)
            begin
                lastl_v_reg  <= nl_v;
                lastl_reg    <= nl;
                lasth_v_reg  <= nh_v;
                lasth_reg    <= nh;
                fall_acc_reg <= fall_now;
            end

            res_cnt_reg <= res_cnt_next;
            if (res_push)
            begin
                res_wp_reg <= ~res_wp_reg;
            end
            if (res_pop)
            begin
                res_rp_reg <= ~res_rp_reg;
            end
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_mem_reg[res_wp_reg] <= res_new;
        end
    end

    a_res_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res_space || res_pop))
        else $error("result queue overrun");

    a_scan_holds_cmds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !cmd_take)
        else $error("command taken during store scan");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(STORE_DEPTH))
        else $error("write position beyond store");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (pos_reg < POS_W'(STORE_DEPTH)))
        else $error("store write at the wrap position");

endmodule

// ===== rtl/accel_fall_window_detector.sv =====
// Fall-window detector. Items enter through a two-deep command queue
// (push/full) and every item leaves exactly one result through a two-deep
// result queue (pop/empty). Sample, restart and unused-mode items push their
// result when taken, so a stream of them runs at one item per clock while the
// result queue has room. A check item walks the 128-entry sample store
// through the single RAM read port, one entry per clock; until its result is
// pushed, no further item is executed (the command queue still fills).
// The store reads as zero after reset through per-entry valid flags, so
// there is no clearing pass. Configuration writes are taken in any cycle
// (cfg_ready is always high); an index beyond the high threshold is ignored.
module accel_fall_window_detector import afwd_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        mode,
    input  logic [AXIS_W-1:0] accel_x,
    input  logic [AXIS_W-1:0] accel_y,
    input  logic [AXIS_W-1:0] accel_z,
    input  logic              vibrating,
    input  logic              batch_end,
    output logic              empty,
    input  logic              pop,
    output logic              fall_detected,
    output logic              buffer_full,
    output logic [FILL_W-1:0] fill_position,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    cfg_t cfg_reg;
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;
    logic cfg_xfer;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window <= WINDOW_RST;
            cfg_reg.low    <= LOW_RST;
            cfg_reg.high   <= HIGH_RST;
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                REG_WINDOW: cfg_reg.window <= cfg_data[WIN_W-1:0];
                REG_LOW:    cfg_reg.low    <= cfg_data[THR_W-1:0];
                REG_HIGH:   cfg_reg.high   <= cfg_data[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    afwd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .vibrating (vibrating),
        .batch_end (batch_end),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    afwd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_take      (cmd_take),
        .empty         (empty),
        .pop           (pop),
        .fall_detected (fall_detected),
        .buffer_full   (buffer_full),
        .fill_position (fill_position)
    );

endmodule
